[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent assertions used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that is also checked while the reset is high.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/spms_pkg.sv]
// ----------------------------------------------------------------------------
// Syringe pump move sequencer package
// Command and result types and the fixed constants of the sequencer.
// ----------------------------------------------------------------------------
package spms_pkg;

   // Largest total step position the syringe may reach.
   localparam int unsigned MAX_STEPS = 6000;

   // Status bits that show the pump is answering.
   localparam logic [15:0] STATUS_LINK_MASK = 16'h0060;

   // Reset value of the timeout register.
   localparam logic [15:0] TIMEOUT_RESET = 16'd300;

   // Register values written by the start-up sequence and fixed commands.
   localparam logic [15:0] BOOT_INPUT_VALVE  = 16'd1;
   localparam logic [15:0] BOOT_OUTPUT_VALVE = 16'd2;
   localparam logic [15:0] RESET_VALUE       = 16'd1;
   localparam logic [15:0] STOP_VALUE        = 16'd1;

   // Input actions.
   typedef enum logic [2:0] {
      ACT_TICK       = 3'd0,
      ACT_START      = 3'd1,
      ACT_RESET      = 3'd2,
      ACT_STOP       = 3'd3,
      ACT_OPEN       = 3'd4,
      ACT_SET_INPUT  = 3'd5,
      ACT_SET_OUTPUT = 3'd6,
      ACT_ARM        = 3'd7
   } action_type;

   // Kinds of move.
   typedef enum logic [1:0] {
      MOVE_DRAIN    = 2'd0,
      MOVE_ABSOLUTE = 2'd1,
      MOVE_SUCK     = 2'd2
   } move_kind_type;

   // Pump registers that a result may write.
   typedef enum logic [2:0] {
      TGT_INPUT_VALVE   = 3'd0,
      TGT_OUTPUT_VALVE  = 3'd1,
      TGT_RESET         = 3'd2,
      TGT_FORCED_STOP   = 3'd3,
      TGT_VALVE_CONTROL = 3'd4,
      TGT_DRAIN         = 3'd5,
      TGT_ABSOLUTE      = 3'd6,
      TGT_SUCK          = 3'd7
   } target_type;

   // A classified command as it waits in the queue.
   typedef struct packed {
      action_type    action;
      logic [7:0]    valve;
      logic [15:0]   steps;
      move_kind_type kind;
      logic          over_max;
      logic          link_up;
      logic [15:0]   position;
      logic [15:0]   valve_now;
   } cmd_type;

   // One result without its last marker.
   typedef struct packed {
      logic        accepted;
      logic        send_valid;
      target_type  send_target;
      logic [15:0] send_value;
      logic        event_valid;
      logic        event_outcome;
   } result_type;

endpackage

[rtl/spms_if.sv]
// ----------------------------------------------------------------------------
// Sequencer channel interfaces
// Valid/ready channels for commands, results and the timeout register.
// ----------------------------------------------------------------------------

// Command and status tick channel.
interface spms_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  valve_number;
   logic [15:0] move_steps;
   logic [1:0]  move_direction;
   logic [15:0] status_word;
   logic [15:0] position_now;
   logic [15:0] valve_now;

   modport source (
      output valid, action, valve_number, move_steps, move_direction,
             status_word, position_now, valve_now,
      input  ready
   );
   modport sink (
      input  valid, action, valve_number, move_steps, move_direction,
             status_word, position_now, valve_now,
      output ready
   );
endinterface

// Result channel.
interface spms_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        send_valid;
   logic [2:0]  send_target;
   logic [15:0] send_value;
   logic        event_valid;
   logic        event_outcome;
   logic        last;

   modport source (
      output valid, accepted, send_valid, send_target, send_value,
             event_valid, event_outcome, last,
      input  ready
   );
   modport sink (
      input  valid, accepted, send_valid, send_target, send_value,
             event_valid, event_outcome, last,
      output ready
   );
endinterface

// Timeout register write channel.
interface spms_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] timeout_ticks;

   modport source (output valid, timeout_ticks, input ready);
   modport sink (input valid, timeout_ticks, output ready);
endinterface

[rtl/spms_front.sv]
// ----------------------------------------------------------------------------
// Sequencer front end
// Accepts command transactions and classifies them for the command queue.
// ----------------------------------------------------------------------------
module spms_front (
   spms_req_if.sink         req_bus,
   input  logic             queue_full,
   output logic             push,
   output spms_pkg::cmd_type push_data
);
   import spms_pkg::*;

   // Take a transaction whenever the queue has room.
   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   // Classify the transaction: decode the action, fold direction three onto
   // suck, check the step bound and reduce the status word to a link flag.
   always_comb begin
      push_data.action    = action_type'(req_bus.action);
      push_data.valve     = req_bus.valve_number;
      push_data.steps     = req_bus.move_steps;
      if (req_bus.move_direction == 2'd3) begin
         push_data.kind = MOVE_SUCK;
      end else begin
         push_data.kind = move_kind_type'(req_bus.move_direction);
      end
      push_data.over_max  = req_bus.move_steps > 16'(MAX_STEPS);
      push_data.link_up   = (req_bus.status_word & STATUS_LINK_MASK) != 16'd0;
      push_data.position  = req_bus.position_now;
      push_data.valve_now = req_bus.valve_now;
   end

endmodule

[rtl/spms_queue.sv]
// ----------------------------------------------------------------------------
// Sequencer command queue
// Short first-in first-out queue of classified commands between the two ends.
// ----------------------------------------------------------------------------
module spms_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spms_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output spms_pkg::cmd_type head,
   output logic              empty
);
   import spms_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/spms_back.sv]
// ----------------------------------------------------------------------------
// Sequencer back end
// Carries out queued commands on the pump state and hands out their results.
// ----------------------------------------------------------------------------
module spms_back (
   input  logic              clock,
   input  logic              reset,
   spms_csr_if.sink          csr_bus,
   input  spms_pkg::cmd_type head,
   input  logic              queue_empty,
   output logic              pop,
   spms_rsp_if.source        rsp_bus
);
   import spms_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_RESET_WAIT  = 3'd1,
      PH_VALVE_START = 3'd2,
      PH_VALVE_WAIT  = 3'd3,
      PH_MOVE_START  = 3'd4,
      PH_MOVE_WAIT   = 3'd5
   } phase_type;

   // Result builders.
   function automatic result_type write_result(target_type tgt, logic [15:0] value);
      result_type r;
      r.accepted      = 1'b1;
      r.send_valid    = 1'b1;
      r.send_target   = tgt;
      r.send_value    = value;
      r.event_valid   = 1'b0;
      r.event_outcome = 1'b0;
      return r;
   endfunction

   function automatic result_type event_result(logic fail);
      result_type r;
      r.accepted      = 1'b1;
      r.send_valid    = 1'b0;
      r.send_target   = TGT_INPUT_VALVE;
      r.send_value    = 16'd0;
      r.event_valid   = 1'b1;
      r.event_outcome = fail;
      return r;
   endfunction

   function automatic result_type plain_result(logic acc);
      result_type r;
      r.accepted      = acc;
      r.send_valid    = 1'b0;
      r.send_target   = TGT_INPUT_VALVE;
      r.send_value    = 16'd0;
      r.event_valid   = 1'b0;
      r.event_outcome = 1'b0;
      return r;
   endfunction

   function automatic target_type move_target(move_kind_type k);
      target_type t;
      case (k)
         MOVE_DRAIN:    t = TGT_DRAIN;
         MOVE_ABSOLUTE: t = TGT_ABSOLUTE;
         default:       t = TGT_SUCK;
      endcase
      return t;
   endfunction

   phase_type     phase_ff, phase_in;
   logic          connected_ff, connected_in;
   logic          first_boot_ff, first_boot_in;
   logic [15:0]   total_ff, total_in;
   logic [15:0]   pending_ff, pending_in;
   logic [7:0]    wanted_ff, wanted_in;
   move_kind_type kind_ff, kind_in;
   logic [15:0]   wait_ff, wait_in;
   logic          armed_ff, armed_in;
   logic [15:0]   timeout_ff, timeout_in;
   logic [1:0]    rem_ff, rem_in;
   logic [1:0]    idx_ff, idx_in;
   result_type    slot_ff [3];
   result_type    slot_in [3];
   result_type    cur;
   logic          fire;
   logic          take;
   logic [15:0]   wait_bump;

   // The timeout register is always ready for a write.
   assign csr_bus.ready = 1'b1;

   // Result register: the slots of the current command, shown in turn.
   assign cur                   = slot_ff[idx_ff];
   assign rsp_bus.valid         = rem_ff != 2'd0;
   assign rsp_bus.accepted      = cur.accepted;
   assign rsp_bus.send_valid    = cur.send_valid;
   assign rsp_bus.send_target   = cur.send_target;
   assign rsp_bus.send_value    = cur.send_value;
   assign rsp_bus.event_valid   = cur.event_valid;
   assign rsp_bus.event_outcome = cur.event_outcome;
   assign rsp_bus.last          = rem_ff == 2'd1;

   // A new command is taken once the last result of the previous one leaves.
   assign fire = rsp_bus.valid && rsp_bus.ready;
   assign take = !queue_empty && (rem_ff == 2'd0 || (rem_ff == 2'd1 && rsp_bus.ready));
   assign pop  = take;

   assign wait_bump = (wait_ff == 16'hFFFF) ? wait_ff : wait_ff + 16'd1;

   // Command execution and result sequencing.
   always_comb begin
      logic [1:0]  n;
      logic        report;
      logic        fail;
      logic [16:0] sum;
      phase_type   ph;
      n             = 2'd0;
      report        = 1'b0;
      fail          = 1'b0;
      sum           = {1'b0, total_ff} + {1'b0, head.steps};
      ph            = phase_ff;
      phase_in      = phase_ff;
      connected_in  = connected_ff;
      first_boot_in = first_boot_ff;
      total_in      = total_ff;
      pending_in    = pending_ff;
      wanted_in     = wanted_ff;
      kind_in       = kind_ff;
      wait_in       = wait_ff;
      armed_in      = armed_ff;
      slot_in       = slot_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      timeout_in    = csr_bus.valid ? csr_bus.timeout_ticks : timeout_ff;

      if (take) begin
         case (head.action)
            ACT_TICK: begin
               connected_in = connected_ff | head.link_up;
               // Issue a pending valve or move write first.
               if (phase_ff == PH_VALVE_START) begin
                  slot_in[0] = write_result(TGT_VALVE_CONTROL, {8'd0, wanted_ff});
                  ph         = PH_VALVE_WAIT;
                  n          = 2'd1;
               end else if (phase_ff == PH_MOVE_START) begin
                  slot_in[0] = write_result(move_target(kind_ff), pending_ff);
                  ph         = PH_MOVE_WAIT;
                  n          = 2'd1;
               end
               // Then check the phase that the write leaves.
               case (ph)
                  PH_IDLE: begin
                     if (first_boot_ff && connected_in) begin
                        slot_in[0]    = write_result(TGT_INPUT_VALVE, BOOT_INPUT_VALVE);
                        slot_in[1]    = write_result(TGT_OUTPUT_VALVE, BOOT_OUTPUT_VALVE);
                        slot_in[2]    = write_result(TGT_RESET, RESET_VALUE);
                        total_in      = 16'd0;
                        wait_in       = 16'd0;
                        ph            = PH_RESET_WAIT;
                        first_boot_in = 1'b0;
                        n             = 2'd3;
                     end
                  end
                  PH_RESET_WAIT: begin
                     if (connected_in && head.position == 16'd0) begin
                        ph     = PH_IDLE;
                        report = 1'b1;
                     end else if (wait_ff > timeout_ff) begin
                        ph     = PH_IDLE;
                        report = 1'b1;
                        fail   = 1'b1;
                     end
                     wait_in = wait_bump;
                  end
                  PH_MOVE_WAIT: begin
                     if (connected_in && head.position == total_ff) begin
                        ph         = PH_IDLE;
                        report     = 1'b1;
                        pending_in = 16'd0;
                     end else if (wait_ff > timeout_ff) begin
                        ph     = PH_IDLE;
                        report = 1'b1;
                        fail   = 1'b1;
                     end
                     wait_in = wait_bump;
                  end
                  PH_VALVE_WAIT: begin
                     if (connected_in && head.valve_now == {8'd0, wanted_ff}) begin
                        ph = (pending_ff != 16'd0) ? PH_MOVE_START : PH_IDLE;
                     end else if (wait_ff > timeout_ff) begin
                        ph     = PH_IDLE;
                        report = 1'b1;
                        fail   = 1'b1;
                     end
                     wait_in = wait_bump;
                  end
                  default: begin
                  end
               endcase
               // A completion event goes out only while one is armed.
               if (report && armed_ff) begin
                  slot_in[n] = event_result(fail);
                  n          = n + 2'd1;
                  armed_in   = 1'b0;
               end
               phase_in = ph;
            end
            ACT_ARM: begin
               armed_in   = 1'b1;
               slot_in[0] = plain_result(1'b1);
               n          = 2'd1;
            end
            default: begin
               n = 2'd1;
               if (!connected_ff) begin
                  slot_in[0] = plain_result(1'b0);
               end else begin
                  case (head.action)
                     ACT_START: begin
                        slot_in[0] = plain_result(1'b0);
                        if (!head.over_max) begin
                           wanted_in  = head.valve;
                           pending_in = head.steps;
                           kind_in    = head.kind;
                           case (head.kind)
                              MOVE_DRAIN: begin
                                 if (total_ff >= head.steps) begin
                                    total_in   = total_ff - head.steps;
                                    slot_in[0] = plain_result(1'b1);
                                 end
                              end
                              MOVE_ABSOLUTE: begin
                                 total_in   = head.steps;
                                 slot_in[0] = plain_result(1'b1);
                              end
                              default: begin
                                 if (sum <= 17'(MAX_STEPS)) begin
                                    total_in   = sum[15:0];
                                    slot_in[0] = plain_result(1'b1);
                                 end
                              end
                           endcase
                           if (slot_in[0].accepted) begin
                              phase_in = PH_VALVE_START;
                              wait_in  = 16'd0;
                           end
                        end
                     end
                     ACT_RESET, ACT_SET_INPUT, ACT_SET_OUTPUT: begin
                        if (head.action == ACT_RESET) begin
                           slot_in[0] = write_result(TGT_RESET, RESET_VALUE);
                        end else if (head.action == ACT_SET_INPUT) begin
                           slot_in[0] = write_result(TGT_INPUT_VALVE, {8'd0, head.valve});
                        end else begin
                           slot_in[0] = write_result(TGT_OUTPUT_VALVE, {8'd0, head.valve});
                        end
                        total_in = 16'd0;
                        wait_in  = 16'd0;
                        phase_in = PH_RESET_WAIT;
                     end
                     ACT_STOP: begin
                        slot_in[0] = write_result(TGT_FORCED_STOP, STOP_VALUE);
                     end
                     default: begin
                        slot_in[0] = write_result(TGT_VALVE_CONTROL, {8'd0, head.valve});
                        phase_in   = PH_VALVE_WAIT;
                     end
                  endcase
               end
            end
         endcase
         rem_in = n;
         idx_in = 2'd0;
      end else if (fire) begin
         rem_in = rem_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   // Pump state, timeout register and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         connected_ff  <= 1'b0;
         first_boot_ff <= 1'b1;
         total_ff      <= 16'd0;
         pending_ff    <= 16'd0;
         wanted_ff     <= 8'd1;
         kind_ff       <= MOVE_DRAIN;
         wait_ff       <= 16'd0;
         armed_ff      <= 1'b0;
         timeout_ff    <= TIMEOUT_RESET;
         rem_ff        <= 2'd0;
         idx_ff        <= 2'd0;
      end else begin
         phase_ff      <= phase_in;
         connected_ff  <= connected_in;
         first_boot_ff <= first_boot_in;
         total_ff      <= total_in;
         pending_ff    <= pending_in;
         wanted_ff     <= wanted_in;
         kind_ff       <= kind_in;
         wait_ff       <= wait_in;
         armed_ff      <= armed_in;
         timeout_ff    <= timeout_in;
         rem_ff        <= rem_in;
         idx_ff        <= idx_in;
      end
      slot_ff <= slot_in;
   end

endmodule

[rtl/syringe_pump_move_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// Syringe pump move sequencer
// Turns pump commands and status ticks into register writes and events.
// ----------------------------------------------------------------------------
//
//   Channel   Port     Direction  Carries
//   command   req_bus  in         action, valve, steps, direction, readback
//   result    rsp_bus  out        write, event, accepted and last marker
//   register  csr_bus  in         timeout_ticks
//
// The back end shows one result per cycle from its result register while
// ready is high, so a command gives one result and a tick gives zero to
// three (a quiet tick gives none).
// The first result of a transaction is offered once it has passed the
// command queue and been loaded into the result register. No memory
// needs clearing on reset. The command queue of QUEUE_DEPTH entries
// keeps accepting while results stall until it is full, and the result
// register holds its contents while ready is low.
module syringe_pump_move_sequencer_unit #(
   parameter int unsigned QUEUE_DEPTH = 4   // two or more
) (
   input  logic       clock,
   input  logic       reset,
   spms_req_if.sink   req_bus,
   spms_rsp_if.source rsp_bus,
   spms_csr_if.sink   csr_bus
);
   import spms_pkg::*;

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;
   cmd_type push_data;
   cmd_type head;

   // Accept and classify.
   spms_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // Command queue.
   spms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   // Execute and hand out results.
   spms_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_bus     (csr_bus),
      .head        (head),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

[rtl/spms_checker.sv]
// ----------------------------------------------------------------------------
// Sequencer port checker
// Watches the result port of the sequencer for ordering and encoding slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spms_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic        rsp_send_valid,
   input logic [2:0]  rsp_send_target,
   input logic [15:0] rsp_send_value,
   input logic        rsp_event_valid,
   input logic        rsp_event_outcome,
   input logic        rsp_last
);

   // A stalled result stays offered unchanged.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted) && $stable(rsp_send_valid) && $stable(rsp_send_target) && $stable(rsp_send_value) && $stable(rsp_event_valid) && $stable(rsp_event_outcome) && $stable(rsp_last), "stalled result changed")

   // Nothing is offered straight after reset.
   `ASSERT_CLK(a_rsp_reset, clock, $past(reset) |-> !rsp_valid, "result offered after reset")

   // A transaction that is not the last of its command is followed at once.
   `ASSERT_CLK_RST(a_rsp_burst, clock, reset, rsp_valid && rsp_ready && !rsp_last |=> rsp_valid, "result burst broken")

   // An event carries no register write.
   `ASSERT_CLK_RST(a_event_plain, clock, reset, rsp_valid && rsp_event_valid |-> rsp_accepted && !rsp_send_valid, "event with write")

   // A rejected command gives one bare result.
   `ASSERT_CLK_RST(a_reject_plain, clock, reset, rsp_valid && !rsp_accepted |-> rsp_last && !rsp_send_valid && !rsp_event_valid, "rejection not bare")

endmodule

bind syringe_pump_move_sequencer_unit spms_checker u_spms_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_accepted      (rsp_bus.accepted),
   .rsp_send_valid    (rsp_bus.send_valid),
   .rsp_send_target   (rsp_bus.send_target),
   .rsp_send_value    (rsp_bus.send_value),
   .rsp_event_valid   (rsp_bus.event_valid),
   .rsp_event_outcome (rsp_bus.event_outcome),
   .rsp_last          (rsp_bus.last)
);
